@@ design/wbct_pkg.sv @@
`timescale 1ns / 1ps
// Work/break cycle timer package: command and phase codes, widths, register map,
// millisecond conversion helpers. No dependencies.
package wbct_pkg;

	typedef enum logic [2:0] {
		OP_TICK        = 3'd0,
		OP_START_WORK  = 3'd1,
		OP_START_SHORT = 3'd2,
		OP_PAUSE       = 3'd3,
		OP_RESUME      = 3'd4,
		OP_RESET       = 3'd5,
		OP_SKIP        = 3'd6,
		OP_TAKE_ALERT  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WORK  = 2'd1,
		PH_SHORT = 2'd2,
		PH_LONG  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_WORK_MIN  = 2'd0,
		REG_SHORT_MIN = 2'd1,
		REG_LONG_MIN  = 2'd2,
		REG_SESSIONS  = 2'd3
	} reg_idx_t;

	localparam int MS_W      = 24;
	localparam int SEC_W     = 14;
	localparam int MIN_W     = 8;
	localparam int ELAPSED_W = 16;
	localparam int COUNT_W   = 16;
	localparam int POS_W     = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [15:0] MS_PER_MIN = 16'd60000;

	// x / 1000 == (x * RECIP) >> 38, exact for any 32-bit x
	localparam int RECIP_W   = 29;
	localparam logic [RECIP_W-1:0] SEC_RECIP = 29'h10624DD3;
	localparam int SEC_SHIFT = 38;
	localparam int PROD_W    = MS_W + RECIP_W;

	localparam logic [MIN_W-1:0] WORK_MIN_RST  = 8'd25;
	localparam logic [MIN_W-1:0] SHORT_MIN_RST = 8'd5;
	localparam logic [MIN_W-1:0] LONG_MIN_RST  = 8'd15;
	localparam logic [POS_W-1:0] SESSIONS_RST  = 4'd4;

	typedef struct packed {
		phase_t              phase;
		logic                paused;
		logic                running;
		logic [MS_W-1:0]     remaining_ms;
		logic [MS_W-1:0]     total_ms;
		logic [COUNT_W-1:0]  sessions;
		logic                taken;
	} status_t;

	function automatic logic [MS_W-1:0] min_to_ms(input logic [MIN_W-1:0] m);
		return MS_W'(m) * MS_W'(MS_PER_MIN);
	endfunction

	function automatic logic [SEC_W-1:0] ms_to_sec(input logic [MS_W-1:0] ms);
		logic [PROD_W-1:0] p;
		p = PROD_W'(ms) * PROD_W'(SEC_RECIP);
		return p[SEC_SHIFT +: SEC_W];
	endfunction

endpackage

@@ design/wbct_if.sv @@
`timescale 1ns / 1ps
// Command and status channel interfaces of the work/break cycle timer.
// Depends on wbct_pkg.
interface wbct_cmd_if;
	import wbct_pkg::*;
	logic                 valid;
	logic                 ready;
	op_t                  op;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic [MIN_W-1:0]     minutes;

	modport source (output valid, output op, output elapsed_ms, output minutes, input ready);
	modport sink   (input valid, input op, input elapsed_ms, input minutes, output ready);
endinterface

interface wbct_status_if;
	import wbct_pkg::*;
	logic               valid;
	logic               ready;
	phase_t             phase;
	logic               is_paused;
	logic               is_running;
	logic [SEC_W-1:0]   remaining_sec;
	logic [SEC_W-1:0]   total_sec;
	logic [COUNT_W-1:0] sessions_done;
	logic               alert_taken;

	modport source (output valid, output phase, output is_paused, output is_running,
		output remaining_sec, output total_sec, output sessions_done, output alert_taken,
		input ready);
	modport sink (input valid, input phase, input is_paused, input is_running,
		input remaining_sec, input total_sec, input sessions_done, input alert_taken,
		output ready);
endinterface

@@ design/work_break_cycle_timer.sv @@
`timescale 1ns / 1ps
// Work/break cycle timer top level: command register, state update, seconds
// conversion and status register. Depends on wbct_pkg and wbct_if.
//
// Usage:
//   cmd carries one command item (op, elapsed_ms, minutes); status returns one
//   item per command with the phase, pause/run flags, remaining and total time in
//   whole seconds, completed work phases and, for take alert, whether an alert
//   was pending. Both use valid/ready; an item moves when both are high.
//   Timer lengths and the long-break spacing are set through the APB port
//   (word registers at 0x0, 0x4, 0x8, 0xC); the user must write them only while
//   no command is in flight, as the block itself does not enforce it.
//   An accepted command passes the command register, the status snapshot register
//   and the output register. Throughput: one command per cycle while status.ready
//   is high; the state update for each command sits between the command register
//   and the status snapshot register, and the ms-to-seconds multiply sits before
//   the output register. Reset clears the timer state and pipeline, loads default
//   register values. When status.ready is low the three stages fill up one by one
//   and cmd.ready drops only once all of them hold items.
module work_break_cycle_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	wbct_cmd_if.sink                       cmd,
	wbct_status_if.source                  status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wbct_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wbct_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wbct_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import wbct_pkg::*;

	// configuration
	logic [MIN_W-1:0] work_min_q, short_min_q, long_min_q;
	logic [POS_W-1:0] sessions_q;
	logic [MS_W-1:0]  work_ms_q, short_ms_q, long_ms_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// timer state
	phase_t             phase_q;
	logic               paused_q;
	logic [MS_W-1:0]    rem_q, total_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   pos_q;
	logic               alert_q;

	phase_t             phase_d;
	logic               paused_d;
	logic [MS_W-1:0]    rem_d, total_d;
	logic [COUNT_W-1:0] count_d;
	logic [POS_W-1:0]   pos_d;
	logic               alert_d;
	logic               taken_d;
	logic [POS_W-1:0]   pos_inc, limit;

	// pipeline
	logic                 valid_s1, valid_s2, out_valid_q;
	logic                 adv_s1, adv_s2, adv_out;
	op_t                  op_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [MS_W-1:0]      start_ms_s1;
	status_t              st_s2;

	phase_t             res_phase_q;
	logic               res_paused_q, res_running_q, res_taken_q;
	logic [SEC_W-1:0]   res_rem_q, res_total_q;
	logic [COUNT_W-1:0] res_count_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_WORK_MIN:  prdata = APB_DATA_W'(work_min_q);
			REG_SHORT_MIN: prdata = APB_DATA_W'(short_min_q);
			REG_LONG_MIN:  prdata = APB_DATA_W'(long_min_q);
			REG_SESSIONS:  prdata = APB_DATA_W'(sessions_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_min_q  <= WORK_MIN_RST;
			short_min_q <= SHORT_MIN_RST;
			long_min_q  <= LONG_MIN_RST;
			sessions_q  <= SESSIONS_RST;
			work_ms_q   <= min_to_ms(WORK_MIN_RST);
			short_ms_q  <= min_to_ms(SHORT_MIN_RST);
			long_ms_q   <= min_to_ms(LONG_MIN_RST);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WORK_MIN: begin
					work_min_q <= pwdata[MIN_W-1:0];
					work_ms_q  <= min_to_ms(pwdata[MIN_W-1:0]);
				end
				REG_SHORT_MIN: begin
					short_min_q <= pwdata[MIN_W-1:0];
					short_ms_q  <= min_to_ms(pwdata[MIN_W-1:0]);
				end
				REG_LONG_MIN: begin
					long_min_q <= pwdata[MIN_W-1:0];
					long_ms_q  <= min_to_ms(pwdata[MIN_W-1:0]);
				end
				REG_SESSIONS: sessions_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_out   = !out_valid_q || status.ready;
	assign adv_s2    = !valid_s2 || adv_out;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)  valid_s1    <= cmd.valid;
			if (adv_s2)  valid_s2    <= valid_s1;
			if (adv_out) out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			op_s1       <= cmd.op;
			elapsed_s1  <= cmd.elapsed_ms;
			start_ms_s1 <= min_to_ms(cmd.minutes);
		end
	end

	// state update
	assign limit   = (sessions_q == '0) ? POS_W'(1) : sessions_q;
	assign pos_inc = pos_q + POS_W'(1);

	always_comb begin
		phase_d  = phase_q;
		paused_d = paused_q;
		rem_d    = rem_q;
		total_d  = total_q;
		count_d  = count_q;
		pos_d    = pos_q;
		alert_d  = alert_q;
		taken_d  = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (phase_q != PH_IDLE && !paused_q) begin
					if (MS_W'(elapsed_s1) < rem_q) begin
						rem_d = rem_q - MS_W'(elapsed_s1);
					end else begin
						alert_d = 1'b1;
						if (phase_q == PH_WORK) begin
							count_d = count_q + COUNT_W'(1);
							if (pos_inc >= limit) begin
								pos_d   = '0;
								phase_d = PH_LONG;
								total_d = long_ms_q;
							end else begin
								pos_d   = pos_inc;
								phase_d = PH_SHORT;
								total_d = short_ms_q;
							end
						end else begin
							phase_d = PH_WORK;
							total_d = work_ms_q;
						end
						rem_d = total_d;
					end
				end
			end
			OP_START_WORK, OP_START_SHORT: begin
				phase_d  = (op_s1 == OP_START_WORK) ? PH_WORK : PH_SHORT;
				total_d  = start_ms_s1;
				rem_d    = start_ms_s1;
				paused_d = 1'b0;
			end
			OP_PAUSE: begin
				if (phase_q != PH_IDLE) paused_d = 1'b1;
			end
			OP_RESUME: paused_d = 1'b0;
			OP_RESET: begin
				phase_d  = PH_IDLE;
				paused_d = 1'b0;
				rem_d    = '0;
				total_d  = '0;
				count_d  = '0;
				pos_d    = '0;
				alert_d  = 1'b0;
			end
			OP_SKIP: rem_d = '0;
			OP_TAKE_ALERT: begin
				taken_d = alert_q;
				alert_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			paused_q <= 1'b0;
			rem_q    <= '0;
			total_q  <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			alert_q  <= 1'b0;
		end else if (valid_s1 && adv_s2) begin
			phase_q  <= phase_d;
			paused_q <= paused_d;
			rem_q    <= rem_d;
			total_q  <= total_d;
			count_q  <= count_d;
			pos_q    <= pos_d;
			alert_q  <= alert_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			st_s2.phase        <= phase_d;
			st_s2.paused       <= paused_d;
			st_s2.running      <= (phase_d != PH_IDLE) && !paused_d;
			st_s2.remaining_ms <= rem_d;
			st_s2.total_ms     <= total_d;
			st_s2.sessions     <= count_d;
			st_s2.taken        <= taken_d;
		end
	end

	// seconds conversion into the output register
	always_ff @(posedge clk) begin
		if (valid_s2 && adv_out) begin
			res_phase_q   <= st_s2.phase;
			res_paused_q  <= st_s2.paused;
			res_running_q <= st_s2.running;
			res_rem_q     <= ms_to_sec(st_s2.remaining_ms);
			res_total_q   <= ms_to_sec(st_s2.total_ms);
			res_count_q   <= st_s2.sessions;
			res_taken_q   <= st_s2.taken;
		end
	end

	assign status.valid         = out_valid_q;
	assign status.phase         = res_phase_q;
	assign status.is_paused     = res_paused_q;
	assign status.is_running    = res_running_q;
	assign status.remaining_sec = res_rem_q;
	assign status.total_sec     = res_total_q;
	assign status.sessions_done = res_count_q;
	assign status.alert_taken   = res_taken_q;

endmodule

@@ design/wbct_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the work/break cycle timer, bound to the top level.
// Depends on wbct_pkg.
module wbct_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        status_valid,
	input logic                        status_ready,
	input wbct_pkg::phase_t            phase,
	input logic                        is_paused,
	input logic                        is_running,
	input logic [wbct_pkg::SEC_W-1:0]  remaining_sec,
	input logic [wbct_pkg::SEC_W-1:0]  total_sec,
	input logic [wbct_pkg::COUNT_W-1:0] sessions_done,
	input logic                        alert_taken
);
	import wbct_pkg::*;

	a_no_valid_in_reset: assert property (@(posedge clk) !arst_n |-> !status_valid)
		else $error("status valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid && $stable(phase)
			&& $stable(remaining_sec) && $stable(sessions_done) && $stable(alert_taken))
		else $error("stalled status item changed");

	a_run_flag: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> is_running == ((phase != PH_IDLE) && !is_paused))
		else $error("running flag inconsistent with phase and pause");

	a_idle_unpaused: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && phase == PH_IDLE |-> !is_paused)
		else $error("paused while idle");

	a_rem_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> remaining_sec <= total_sec)
		else $error("remaining time exceeds phase length");

endmodule

bind work_break_cycle_timer wbct_checker u_wbct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.status_valid  (status.valid),
	.status_ready  (status.ready),
	.phase         (status.phase),
	.is_paused     (status.is_paused),
	.is_running    (status.is_running),
	.remaining_sec (status.remaining_sec),
	.total_sec     (status.total_sec),
	.sessions_done (status.sessions_done),
	.alert_taken   (status.alert_taken)
);

@@ tb/work_break_cycle_timer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for work_break_cycle_timer: directed table, then random
// commands under several register settings, checked against a timer predictor.
// Depends on wbct_pkg, wbct_if and the work_break_cycle_timer RTL.
module work_break_cycle_timer_tb;
	import wbct_pkg::*;

	localparam int          CYCLE_LIMIT   = 600000;
	localparam int          ITEMS_PER_SET = 200;
	localparam int          NUM_SETS      = 7;
	localparam logic [31:0] MS_IN_MINUTE  = 32'd60000;
	localparam logic [23:0] MS_IN_SECOND  = 24'd1000;

	typedef struct packed {
		phase_t             phase;
		logic               paused;
		logic               running;
		logic [SEC_W-1:0]   rem_sec;
		logic [SEC_W-1:0]   total_sec;
		logic [COUNT_W-1:0] sessions;
		logic               taken;
	} timer_status_t;

	typedef struct {
		op_t                  op;
		logic [ELAPSED_W-1:0] elapsed;
		logic [MIN_W-1:0]     mins;
		bit                   fixed;
		timer_status_t        want;
	} cmd_row_t;

	localparam timer_status_t IDLE_ST = '0;

	cmd_row_t directed_rows [25] = '{
		'{OP_TICK,        16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_PAUSE,       16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_RESUME,      16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_TAKE_ALERT,  16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_SKIP,        16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_START_WORK,  16'd0,     8'd0,   1'b1,
			'{PH_WORK, 1'b0, 1'b1, 14'd0, 14'd0, 16'd0, 1'b0}},
		'{OP_TICK,        16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_TAKE_ALERT,  16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd300, 14'd300, 16'd1, 1'b1}},
		'{OP_TAKE_ALERT,  16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_PAUSE,       16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b1, 1'b0, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_TICK,        16'hFFFF,  8'd0,   1'b1,
			'{PH_SHORT, 1'b1, 1'b0, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_RESUME,      16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_RESUME,      16'd0,     8'd0,   1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd300, 14'd300, 16'd1, 1'b0}},
		'{OP_TICK,        16'hFFFF,  8'd0,   1'b0, IDLE_ST},
		'{OP_SKIP,        16'd0,     8'd0,   1'b0, IDLE_ST},
		'{OP_TICK,        16'd0,     8'd0,   1'b1,
			'{PH_WORK, 1'b0, 1'b1, 14'd1500, 14'd1500, 16'd1, 1'b0}},
		'{OP_START_SHORT, 16'd0,     8'd255, 1'b1,
			'{PH_SHORT, 1'b0, 1'b1, 14'd15300, 14'd15300, 16'd1, 1'b0}},
		'{OP_START_WORK,  16'd0,     8'd255, 1'b1,
			'{PH_WORK, 1'b0, 1'b1, 14'd15300, 14'd15300, 16'd1, 1'b0}},
		'{OP_TICK,        16'hFFFF,  8'd0,   1'b0, IDLE_ST},
		'{OP_PAUSE,       16'd0,     8'd0,   1'b0, IDLE_ST},
		'{OP_SKIP,        16'd0,     8'd0,   1'b0, IDLE_ST},
		'{OP_TICK,        16'd1,     8'd0,   1'b0, IDLE_ST},
		'{OP_RESET,       16'd0,     8'd0,   1'b1, IDLE_ST},
		'{OP_START_WORK,  16'd0,     8'd1,   1'b1,
			'{PH_WORK, 1'b0, 1'b1, 14'd60, 14'd60, 16'd0, 1'b0}},
		'{OP_TICK,        16'd60000, 8'd0,   1'b0, IDLE_ST}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	wbct_cmd_if    cmd_if ();
	wbct_status_if status_if ();

	work_break_cycle_timer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.status  (status_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted timer state and register copies
	phase_t             t_phase;
	logic               t_paused;
	logic [MS_W-1:0]    t_rem_ms;
	logic [MS_W-1:0]    t_total_ms;
	logic [COUNT_W-1:0] t_done;
	logic [POS_W-1:0]   t_pos;
	logic               t_alert;
	logic [MIN_W-1:0]   cfg_work;
	logic [MIN_W-1:0]   cfg_short;
	logic [MIN_W-1:0]   cfg_long;
	logic [POS_W-1:0]   cfg_sessions;

	timer_status_t status_q [$];
	int            errors;
	int            cycles;
	bit            calm;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void clear_timer();
		t_phase    = PH_IDLE;
		t_paused   = 1'b0;
		t_rem_ms   = '0;
		t_total_ms = '0;
		t_done     = '0;
		t_pos      = '0;
		t_alert    = 1'b0;
	endfunction

	function automatic void load_phase(phase_t ph, logic [MIN_W-1:0] mins);
		t_phase    = ph;
		t_total_ms = MS_W'(32'(mins) * MS_IN_MINUTE);
		t_rem_ms   = t_total_ms;
		t_paused   = 1'b0;
	endfunction

	function automatic timer_status_t advance_timer(op_t op, logic [ELAPSED_W-1:0] elapsed,
		logic [MIN_W-1:0] mins);
		timer_status_t s;
		logic [POS_W-1:0] spacing;
		s = '0;
		case (op)
			OP_TICK: begin
				if (t_phase != PH_IDLE && !t_paused) begin
					if (MS_W'(elapsed) < t_rem_ms) begin
						t_rem_ms = t_rem_ms - MS_W'(elapsed);
					end else begin
						t_rem_ms = '0;
						t_alert  = 1'b1;
						if (t_phase == PH_WORK) begin
							t_done  = t_done + 1'b1;
							spacing = (cfg_sessions == '0) ? POS_W'(1) : cfg_sessions;
							t_pos   = t_pos + 1'b1;
							if (t_pos >= spacing) begin
								t_pos = '0;
								load_phase(PH_LONG, cfg_long);
							end else begin
								load_phase(PH_SHORT, cfg_short);
							end
						end else begin
							load_phase(PH_WORK, cfg_work);
						end
					end
				end
			end
			OP_START_WORK: load_phase(PH_WORK, mins);
			OP_START_SHORT: load_phase(PH_SHORT, mins);
			OP_PAUSE: begin
				if (t_phase != PH_IDLE)
					t_paused = 1'b1;
			end
			OP_RESUME: t_paused = 1'b0;
			OP_RESET: clear_timer();
			OP_SKIP: t_rem_ms = '0;
			default: begin
				s.taken = t_alert;
				t_alert = 1'b0;
			end
		endcase
		s.phase     = t_phase;
		s.paused    = t_paused;
		s.running   = (t_phase != PH_IDLE) && !t_paused;
		s.rem_sec   = SEC_W'(t_rem_ms / MS_IN_SECOND);
		s.total_sec = SEC_W'(t_total_ms / MS_IN_SECOND);
		s.sessions  = t_done;
		return s;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// status sink: random stalls, compares each item with the oldest expectation
	initial begin
		timer_status_t want;
		int stall_left;
		stall_left = 0;
		status_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && status_if.valid && status_if.ready) begin
				if (status_q.size() == 0) begin
					$error("status item with nothing expected");
					errors++;
				end else begin
					want = status_q.pop_front();
					check_field("phase", want.phase, status_if.phase);
					check_field("is_paused", want.paused, status_if.is_paused);
					check_field("is_running", want.running, status_if.is_running);
					check_field("remaining_sec", want.rem_sec, status_if.remaining_sec);
					check_field("total_sec", want.total_sec, status_if.total_sec);
					check_field("sessions_done", want.sessions, status_if.sessions_done);
					check_field("alert_taken", want.taken, status_if.alert_taken);
				end
			end
			if (stall_left > 0) begin
				status_if.ready <= 1'b0;
				stall_left--;
			end else begin
				status_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_cmd(input op_t op, input logic [ELAPSED_W-1:0] elapsed,
		input logic [MIN_W-1:0] mins, input bit fixed, input timer_status_t fixed_want);
		int gap;
		timer_status_t pred;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.op         <= op;
		cmd_if.elapsed_ms <= elapsed;
		cmd_if.minutes    <= mins;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		pred = advance_timer(op, elapsed, mins);
		status_q.push_back(fixed ? fixed_want : pred);
	endtask

	task automatic apb_transfer(input bit wr, input reg_idx_t idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_cfg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] rd;
		mask = (idx == REG_SESSIONS) ? 32'hF : 32'hFF;
		apb_transfer(1'b1, idx, ($urandom & ~mask) | (value & mask), rd);
		case (idx)
			REG_WORK_MIN: cfg_work = MIN_W'(value);
			REG_SHORT_MIN: cfg_short = MIN_W'(value);
			REG_LONG_MIN: cfg_long = MIN_W'(value);
			default: cfg_sessions = POS_W'(value);
		endcase
		@(posedge clk);
		apb_transfer(1'b0, idx, $urandom, rd);
		check_field("register readback", value & mask, rd & mask);
		@(posedge clk);
	endtask

	task automatic drain_status();
		cmd_if.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		op_t op;
		logic [ELAPSED_W-1:0] elapsed;
		logic [MIN_W-1:0] mins;
		int r;
		errors = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.op = OP_TICK;
		cmd_if.elapsed_ms = '0;
		cmd_if.minutes = '0;
		cfg_work = WORK_MIN_RST;
		cfg_short = SHORT_MIN_RST;
		cfg_long = LONG_MIN_RST;
		cfg_sessions = SESSIONS_RST;
		clear_timer();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].op, directed_rows[i].elapsed, directed_rows[i].mins,
				directed_rows[i].fixed, directed_rows[i].want);

		for (int set = 0; set < NUM_SETS; set++) begin
			drain_status();
			repeat (4) @(posedge clk);
			case (set)
				0: begin
					write_cfg(REG_WORK_MIN, 0);
					write_cfg(REG_SHORT_MIN, 0);
					write_cfg(REG_LONG_MIN, 0);
					write_cfg(REG_SESSIONS, 0);
				end
				1: begin
					write_cfg(REG_WORK_MIN, 255);
					write_cfg(REG_SHORT_MIN, 255);
					write_cfg(REG_LONG_MIN, 255);
					write_cfg(REG_SESSIONS, 15);
				end
				2: begin
					write_cfg(REG_WORK_MIN, 1);
					write_cfg(REG_SHORT_MIN, 1);
					write_cfg(REG_LONG_MIN, 2);
					write_cfg(REG_SESSIONS, 1);
				end
				3: begin
					write_cfg(REG_WORK_MIN, 2);
					write_cfg(REG_SHORT_MIN, 1);
					write_cfg(REG_LONG_MIN, 3);
					write_cfg(REG_SESSIONS, 15);
				end
				4: begin
					write_cfg(REG_WORK_MIN, 1);
					write_cfg(REG_SHORT_MIN, 0);
					write_cfg(REG_LONG_MIN, 1);
					write_cfg(REG_SESSIONS, 4);
				end
				5: begin
					write_cfg(REG_WORK_MIN, $urandom_range(0, 3));
					write_cfg(REG_SHORT_MIN, $urandom_range(0, 3));
					write_cfg(REG_LONG_MIN, $urandom_range(0, 3));
					write_cfg(REG_SESSIONS, $urandom_range(0, 15));
				end
				default: begin
					write_cfg(REG_WORK_MIN, $urandom_range(0, 255));
					write_cfg(REG_SHORT_MIN, $urandom_range(0, 255));
					write_cfg(REG_LONG_MIN, $urandom_range(0, 255));
					write_cfg(REG_SESSIONS, $urandom_range(1, 15));
				end
			endcase
			@(posedge clk);

			for (int k = 0; k < ITEMS_PER_SET; k++) begin
				if (k % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (k == ITEMS_PER_SET / 2)
					drain_status();
				r = $urandom_range(0, 99);
				if (r < 50)
					op = OP_TICK;
				else if (r < 56)
					op = OP_START_WORK;
				else if (r < 62)
					op = OP_START_SHORT;
				else if (r < 68)
					op = OP_PAUSE;
				else if (r < 76)
					op = OP_RESUME;
				else if (r < 78)
					op = OP_RESET;
				else if (r < 86)
					op = OP_SKIP;
				else
					op = OP_TAKE_ALERT;
				r = $urandom_range(0, 99);
				if (r < 40)
					elapsed = ELAPSED_W'($urandom);
				else if (r < 60)
					elapsed = '1;
				else if (r < 75)
					elapsed = '0;
				else if (r < 90)
					elapsed = ELAPSED_W'($urandom_range(0, 2000));
				else
					elapsed = ELAPSED_W'($urandom_range(59999, 60001));
				r = $urandom_range(0, 99);
				if (r < 70)
					mins = MIN_W'($urandom_range(0, 3));
				else if (r < 85)
					mins = '1;
				else
					mins = MIN_W'($urandom);
				send_cmd(op, elapsed, mins, 1'b0, IDLE_ST);
			end
		end

		calm = 1'b0;
		drain_status();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ work_break_cycle_timer.f @@
design/wbct_pkg.sv
design/wbct_if.sv
design/work_break_cycle_timer.sv
design/wbct_checker.sv
tb/work_break_cycle_timer_tb.sv
